// ===== sv/prr_pkg.sv =====
package prr_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_SHORT = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_t;

  // products below one second of microseconds give no tick
  localparam logic [63:0] US_PER_SECOND = 64'd1000000;
  // products from (2**32 + 1) * 1e6 up give a prescale ratio above the limit
  localparam logic [63:0] LONG_PROD = 64'd4294967297000000;
  // ceil(2**60 / 15625), exact quotient for dividends below 2**46
  localparam logic [46:0] RECIP = 47'd73786976294839;
  localparam logic [31:0] RESET_HZ = 32'd100000000;

  // ratio limit is 2**DIV_LIMIT_LOG2
  localparam int unsigned DIV_LIMIT_LOG2 = 16;
  localparam int unsigned PSC_W = DIV_LIMIT_LOG2 + 1;
  localparam int unsigned LIM_TICKS_W = 2 * DIV_LIMIT_LOG2 + 1;

  typedef struct packed {
    status_t          status;
    logic [PSC_W-1:0] psc;
  } psc_side_t;

endpackage

// ===== sv/prr_mul.sv =====
module prr_mul import prr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [63:0] prod
);

  logic [31:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic        v1;

  // four 16x16 partial products, then one summing stage
  always_ff @(posedge clk) begin
    pp_ll <= a[15:0] * b[15:0];
    pp_lh <= a[15:0] * b[31:16];
    pp_hl <= a[31:16] * b[15:0];
    pp_hh <= a[31:16] * b[31:16];
    prod  <= {pp_hh, pp_ll} + {16'd0, pp_lh, 16'd0} + {16'd0, pp_hl, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

endmodule

// ===== sv/prr_divpipe.sv =====
module prr_divpipe import prr_pkg::*; #(
  parameter int unsigned DW = 64,
  parameter int unsigned QW = 45,
  parameter int unsigned VW = 20,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [SW-1:0] out_side
);

  // one quotient bit per stage, restoring
  logic          valid [QW+1];
  logic [VW-1:0] rem   [QW+1];
  logic [QW-1:0] low   [QW+1];
  logic [QW-1:0] quot  [QW+1];
  logic [VW-1:0] dvs   [QW+1];
  logic [SW-1:0] side  [QW+1];

  assign valid[0] = in_valid;
  assign rem[0]   = VW'(in_dividend[DW-1:QW]);
  assign low[0]   = in_dividend[QW-1:0];
  assign quot[0]  = '0;
  assign dvs[0]   = in_divisor;
  assign side[0]  = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [VW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem[i], low[i][QW-1]};
      ge    = trial >= {1'b0, dvs[i]};
    end

    always_ff @(posedge clk) begin
      rem[i+1]  <= ge ? VW'(trial - {1'b0, dvs[i]}) : trial[VW-1:0];
      low[i+1]  <= low[i] << 1;
      quot[i+1] <= {quot[i][QW-2:0], ge};
      dvs[i+1]  <= dvs[i];
      side[i+1] <= side[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
    end
  end

  assign out_valid = valid[QW];
  assign out_quot  = quot[QW];
  assign out_side  = side[QW];

endmodule

// ===== sv/period_to_prescaler_reload.sv =====
// pipeline: multiply, reciprocal multiply, ratio, count divide and output stages, in that order;
// throughput: one item per cycle, busy is always low
// the receiver cannot stall; results come out in order, one done strobe per item
// synchronous active-high reset clears all valid bits and sets source_clock_hz
// to 100000000
module period_to_prescaler_reload import prr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] req_period,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        done,
  output logic [15:0] prescaler,
  output logic [15:0] reload,
  output logic [1:0]  status
);

  logic [31:0] source_clock_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_clock_hz <= RESET_HZ;
    end else if (cfg_we) begin
      source_clock_hz <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  logic        mul_valid;
  logic [63:0] mul_prod;

  prr_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .a         (source_clock_hz),
    .b         (req_period),
    .out_valid (mul_valid),
    .prod      (mul_prod)
  );

  logic        rc_valid;
  logic        rc_short;
  logic        rc_long;
  logic [63:0] rc_ll;
  logic [46:0] rc_lh;
  logic [45:0] rc_hl;
  logic [28:0] rc_hh;

  // ticks = (product >> 6) / 15625 by reciprocal multiply; exact below the
  // too-long bound, where product >> 6 fits in 46 bits
  always_ff @(posedge clk) begin
    rc_short <= mul_prod < US_PER_SECOND;
    rc_long  <= mul_prod >= LONG_PROD;
    rc_ll    <= 64'(mul_prod[37:6]) * 64'(RECIP[31:0]);
    rc_lh    <= 47'(mul_prod[37:6]) * 47'(RECIP[46:32]);
    rc_hl    <= 46'(mul_prod[51:38]) * 46'(RECIP[31:0]);
    rc_hh    <= 29'(mul_prod[51:38]) * 29'(RECIP[46:32]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc_valid <= 1'b0;
    end else begin
      rc_valid <= mul_valid;
    end
  end

  logic        tk_valid;
  logic        tk_short;
  logic        tk_long;
  logic [60:0] tk_sum;

  // bits 92:32 of the full reciprocal product
  always_ff @(posedge clk) begin
    tk_short <= rc_short;
    tk_long  <= rc_long;
    tk_sum   <= {rc_hh, rc_ll[63:32]} + 61'(rc_lh) + 61'(rc_hl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tk_valid <= 1'b0;
    end else begin
      tk_valid <= rc_valid;
    end
  end

  logic [LIM_TICKS_W-1:0] tk_ticks;
  logic                   rt_valid;
  logic [LIM_TICKS_W-1:0] rt_ticks;
  psc_side_t              rt_side;
  logic [LIM_TICKS_W-1:0] rt_round;

  assign tk_ticks = tk_sum[60:28];

  always_comb begin
    // ceil(ticks / limit); fits since ticks <= limit**2 on the ok path
    rt_round = tk_ticks + LIM_TICKS_W'((1 << DIV_LIMIT_LOG2) - 1);
  end

  always_ff @(posedge clk) begin
    rt_ticks    <= tk_ticks;
    rt_side.psc <= rt_round[LIM_TICKS_W-1:DIV_LIMIT_LOG2];
    priority if (tk_short) begin
      rt_side.status <= STATUS_TOO_SHORT;
    end else if (tk_long) begin
      rt_side.status <= STATUS_TOO_LONG;
    end else begin
      rt_side.status <= STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_valid <= 1'b0;
    end else begin
      rt_valid <= tk_valid;
    end
  end

  logic             cd_valid;
  logic [PSC_W-1:0] cd_quot;
  psc_side_t        cd_side;

  // reload count = ticks / prescale ratio
  prr_divpipe #(
    .DW (LIM_TICKS_W),
    .QW (PSC_W),
    .VW (PSC_W),
    .SW ($bits(psc_side_t))
  ) u_count_div (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (rt_valid),
    .in_dividend (rt_ticks),
    .in_divisor  (rt_side.psc),
    .in_side     (rt_side),
    .out_valid   (cd_valid),
    .out_quot    (cd_quot),
    .out_side    (cd_side)
  );

  always_ff @(posedge clk) begin
    status <= cd_side.status;
    if (cd_side.status == STATUS_OK) begin
      prescaler <= 16'(cd_side.psc - PSC_W'(1));
      reload    <= 16'(cd_quot - PSC_W'(1));
    end else begin
      prescaler <= '0;
      reload    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cd_valid;
    end
  end

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##23 done)
    else $error("item lost in pipeline");

  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 23))
    else $error("done without a matching item");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    done && status != STATUS_OK |-> prescaler == 16'd0 && reload == 16'd0)
    else $error("error result with nonzero fields");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == STATUS_OK || status == STATUS_TOO_SHORT || status == STATUS_TOO_LONG)
    else $error("bad status code");

endmodule
